// File: hdl/ppma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppma_pkg
// Shared constants, types and helpers of the pillar point mean accumulator.
// ----------------------------------------------------------------------------
package ppma_pkg;

  localparam int GRID_COLUMNS = 512;
  localparam int GRID_ROWS    = 512;
  localparam int COUNT_WIDTH  = 16;

  localparam int CELL_TOTAL = GRID_COLUMNS * GRID_ROWS;
  localparam int CELL_W     = $clog2(CELL_TOTAL);
  localparam int SUM_W      = 32;
  localparam int COORD_W    = 16;
  localparam int STEP_W     = $clog2(SUM_W);

  typedef logic [1:0]             op_t;
  typedef logic [1:0]             status_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [CELL_W-1:0]      cell_idx_t;

  localparam op_t OP_ACCUMULATE = 2'd0;
  localparam op_t OP_QUERY      = 2'd1;
  localparam op_t OP_CLEAR      = 2'd2;
  localparam op_t OP_UNUSED     = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_SATURATED = 2'd2;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    sum_t   sum_x;
    sum_t   sum_y;
    sum_t   sum_z;
    count_t count;
  } entry_t;

  // count as reported on the 16-bit result field
  function automatic logic [15:0] report_count(input count_t c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'd65535) ? 16'hFFFF : w[15:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/ppma_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppma_in_if / ppma_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface ppma_in_if;
  logic                valid;
  logic                ready;
  ppma_pkg::op_t       operation;
  logic [8:0]          cell_x;
  logic [8:0]          cell_y;
  logic signed [15:0]  point_x;
  logic signed [15:0]  point_y;
  logic signed [15:0]  point_z;
  modport source (output valid, operation, cell_x, cell_y, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, operation, cell_x, cell_y, point_x, point_y, point_z,
                  output ready);
endinterface

interface ppma_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  mean_x;
  logic signed [15:0]  mean_y;
  logic signed [15:0]  mean_z;
  logic [15:0]         member_count;
  ppma_pkg::status_t   status;
  modport source (output valid, mean_x, mean_y, mean_z, member_count, status,
                  input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, member_count, status,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/ppma_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppma_div
// Three-lane bit-serial signed divider, one quotient bit per cycle per lane,
// with the quotient saturated to 16 bits.
// ----------------------------------------------------------------------------
module ppma_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ppma_pkg::sum_t    sum_x,
  input  wire ppma_pkg::sum_t    sum_y,
  input  wire ppma_pkg::sum_t    sum_z,
  input  wire ppma_pkg::count_t  den,
  output logic                   done,
  output logic signed [15:0]     mean_x,
  output logic signed [15:0]     mean_y,
  output logic signed [15:0]     mean_z
);

  localparam int CW = ppma_pkg::COUNT_WIDTH;
  localparam int SW = ppma_pkg::SUM_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [ppma_pkg::STEP_W-1:0]   step_r, step_nxt;
  ppma_pkg::count_t              den_r;
  logic                          neg_r [3];
  logic [CW:0]                   rem_r [3];
  logic [SW-1:0]                 quo_r [3];
  logic [SW-1:0]                 dvd   [3];
  logic [15:0]                   mean  [3];

  assign dvd[0] = sum_x;
  assign dvd[1] = sum_y;
  assign dvd[2] = sum_z;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (step_r == ppma_pkg::STEP_W'(SW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [CW:0] rem_sh;
    logic [CW:0] rem_sub;
    logic [SW-1:0] q_neg;
    always_comb begin
      rem_sh  = {rem_r[l][CW-1:0], quo_r[l][SW-1]};
      rem_sub = rem_sh - {1'b0, den_r};
      q_neg   = -quo_r[l];
      if (!neg_r[l]) begin
        mean[l] = (quo_r[l] > SW'(32767)) ? 16'h7FFF : quo_r[l][15:0];
      end else begin
        mean[l] = (quo_r[l] > SW'(32768)) ? 16'h8000 : q_neg[15:0];
      end
    end
    always_ff @(posedge clk) begin
      if (start) begin
        neg_r[l] <= dvd[l][SW-1];
        quo_r[l] <= dvd[l][SW-1] ? -dvd[l] : dvd[l];
        rem_r[l] <= '0;
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r[l] <= rem_sub;
          quo_r[l] <= {quo_r[l][SW-2:0], 1'b1};
        end else begin
          rem_r[l] <= rem_sh;
          quo_r[l] <= {quo_r[l][SW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
    end
  end

  assign done   = done_r;
  assign mean_x = mean[0];
  assign mean_y = mean[1];
  assign mean_z = mean[2];

endmodule
`default_nettype wire

// File: hdl/pillar_point_mean_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pillar_point_mean_accumulator
// Per-cell coordinate sums and point counts in one memory; accumulate, query
// mean and clear operations, one word at a time.
//
//   port     dir   handshake     word
//   in_ch    in    valid/ready   operation, cell_x, cell_y, point_x/y/z
//   out_ch   out   valid/ready   mean_x/y/z, member_count, status
//
// Accumulate, clear and other words pass through accept, memory read and
// result; a query of a non-empty cell also waits for the serial divider.
// After reset a clearing pass writes every cell with in ready low. The
// result register lets the next word be accepted while a result waits;
// a stalled output holds the block in its result state.
// ----------------------------------------------------------------------------
module pillar_point_mean_accumulator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ppma_in_if.sink          in_ch,
  ppma_out_if.source       out_ch
);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic [15:0]        count;
    ppma_pkg::status_t  status;
  } result_t;

  state_t                 state_r, state_nxt;
  ppma_pkg::cell_idx_t    clr_r, clr_nxt;
  ppma_pkg::entry_t       mem [ppma_pkg::CELL_TOTAL];
  ppma_pkg::entry_t       rd_r;
  ppma_pkg::entry_t       wr_data;
  ppma_pkg::cell_idx_t    wr_addr;
  logic                   we;
  ppma_pkg::cell_idx_t    in_idx;
  logic                   in_oob;
  logic                   accept;

  ppma_pkg::op_t          op_r;
  ppma_pkg::cell_idx_t    idx_r;
  logic                   oob_r;
  logic signed [15:0]     px_r, py_r, pz_r;

  result_t                res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r;

  logic                   div_start;
  logic                   div_done;
  logic signed [15:0]     dq_x, dq_y, dq_z;

  assign in_idx = ppma_pkg::CELL_W'(32'(in_ch.cell_y) * 32'(ppma_pkg::GRID_COLUMNS)
                                    + 32'(in_ch.cell_x));
  assign in_oob = (32'(in_ch.cell_x) >= 32'(ppma_pkg::GRID_COLUMNS)) ||
                  (32'(in_ch.cell_y) >= 32'(ppma_pkg::GRID_ROWS));
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.operation;
      idx_r <= in_idx;
      oob_r <= in_oob;
      px_r  <= in_ch.point_x;
      py_r  <= in_ch.point_y;
      pz_r  <= in_ch.point_z;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[in_idx];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '0;
    div_start     = 1'b0;
    case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ppma_pkg::CELL_W'(ppma_pkg::CELL_TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        if (oob_r) begin
          res_nxt.status = (op_r == ppma_pkg::OP_QUERY) ? ppma_pkg::ST_EMPTY
                                                        : ppma_pkg::ST_OK;
        end else begin
          case (op_r)
            ppma_pkg::OP_ACCUMULATE: begin
              if (rd_r.count == ppma_pkg::COUNT_MAX) begin
                res_nxt.count  = ppma_pkg::report_count(rd_r.count);
                res_nxt.status = ppma_pkg::ST_SATURATED;
              end else begin
                we            = 1'b1;
                wr_data.sum_x = rd_r.sum_x + ppma_pkg::SUM_W'(px_r);
                wr_data.sum_y = rd_r.sum_y + ppma_pkg::SUM_W'(py_r);
                wr_data.sum_z = rd_r.sum_z + ppma_pkg::SUM_W'(pz_r);
                wr_data.count = rd_r.count + 1'b1;
                res_nxt.count = ppma_pkg::report_count(wr_data.count);
              end
            end
            ppma_pkg::OP_QUERY: begin
              if (rd_r.count == '0) begin
                res_nxt.status = ppma_pkg::ST_EMPTY;
              end else begin
                res_nxt.count = ppma_pkg::report_count(rd_r.count);
                div_start     = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            ppma_pkg::OP_CLEAR: begin
              we = 1'b1;
            end
            default: begin
              res_nxt.count = ppma_pkg::report_count(rd_r.count);
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt.mean_x = dq_x;
          res_nxt.mean_y = dq_y;
          res_nxt.mean_z = dq_z;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_r <= res_r;
    end
  end

  ppma_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .sum_x  (rd_r.sum_x),
    .sum_y  (rd_r.sum_y),
    .sum_z  (rd_r.sum_z),
    .den    (rd_r.count),
    .done   (div_done),
    .mean_x (dq_x),
    .mean_y (dq_y),
    .mean_z (dq_z)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mean_x       = out_r.mean_x;
  assign out_ch.mean_y       = out_r.mean_y;
  assign out_ch.mean_z       = out_r.mean_z;
  assign out_ch.member_count = out_r.count;
  assign out_ch.status       = out_r.status;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_READ)
    else $error("accepted word not followed by memory read");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLR || state_r == S_READ))
    else $error("memory written outside clear pass or update");

  a_sat_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ppma_pkg::ST_SATURATED) |->
      out_ch.member_count == ppma_pkg::report_count(ppma_pkg::COUNT_MAX))
    else $error("saturated status with unsaturated count");

endmodule
`default_nettype wire
